>>> rtl/frpa_pkg.sv
// shared types and constants of the free page range allocator
`default_nettype none
package frpa_pkg;

  localparam int MAX_RANGES_DEF = 32;
  localparam logic [20:0] PAGE_LIMIT = 21'h100000;
  localparam logic [11:0] PAGE_MASK = 12'hFFF;
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 40;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_ALLOC  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // one free range, pages [start, stop)
  typedef struct packed {
    logic [19:0] start;
    logic [20:0] stop;
  } extent_t;

  typedef struct packed {
    logic shift;
    logic wr;
    logic bump;
  } cell_ctrl_t;

  typedef struct packed {
    logic    emit;
    logic    pop;
    logic    done;
    extent_t piece;
  } merge_out_t;

endpackage
`default_nettype wire

>>> rtl/frpa_cell.sv
// one cell of the range chain: holds one range and takes its neighbor's
`default_nettype none
module frpa_cell (
  input  wire logic                 clk,
  input  wire frpa_pkg::cell_ctrl_t ctrl,
  input  wire frpa_pkg::extent_t    from_next,
  input  wire frpa_pkg::extent_t    wr_data,
  output frpa_pkg::extent_t         q
);

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      q <= wr_data;
    end else if (ctrl.shift) begin
      q <= from_next;
    end else if (ctrl.bump) begin
      q.start <= q.start + 20'd1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/frpa_merge.sv
// range processor at the chain head: merges an added range or cuts a removed one
`default_nettype none
module frpa_merge (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire logic                 restart,
  input  wire logic                 step,
  input  wire logic                 is_add_in,
  input  wire frpa_pkg::extent_t    init,
  input  wire frpa_pkg::extent_t    head,
  input  wire logic                 have_old,
  output frpa_pkg::merge_out_t      mo
);

  frpa_pkg::extent_t orig;
  frpa_pkg::extent_t acc;
  frpa_pkg::extent_t acc_next;
  frpa_pkg::extent_t pend;
  frpa_pkg::extent_t pend_next;
  logic              add_mode;
  logic              inserted;
  logic              inserted_next;
  logic              pend_v;
  logic              pend_v_next;
  logic              p1;
  logic              p2;

  always_comb begin
    mo            = '0;
    acc_next      = acc;
    inserted_next = inserted;
    pend_v_next   = 1'b0;
    pend_next     = pend;
    p1            = head.start < acc.start;
    p2            = acc.stop < head.stop;
    if (pend_v) begin
      mo.emit  = 1'b1;
      mo.piece = pend;
    end else if (have_old) begin
      mo.pop = 1'b1;
      if (add_mode) begin
        if (inserted || (head.stop < {1'b0, acc.start})) begin
          mo.emit  = 1'b1;
          mo.piece = head;
        end else if ({1'b0, head.start} <= acc.stop) begin
          // touching or overlapping: take the union
          acc_next.start = (head.start < acc.start) ? head.start : acc.start;
          acc_next.stop  = (head.stop > acc.stop) ? head.stop : acc.stop;
        end else begin
          mo.emit       = 1'b1;
          mo.piece      = acc;
          inserted_next = 1'b1;
          pend_v_next   = 1'b1;
          pend_next     = head;
        end
      end else begin
        if ((acc.stop <= {1'b0, head.start}) || ({1'b0, acc.start} >= head.stop)) begin
          mo.emit  = 1'b1;
          mo.piece = head;
        end else if (p1) begin
          mo.emit        = 1'b1;
          mo.piece.start = head.start;
          mo.piece.stop  = {1'b0, acc.start};
          if (p2) begin
            // hole in the middle splits the range
            pend_v_next     = 1'b1;
            pend_next.start = acc.stop[19:0];
            pend_next.stop  = head.stop;
          end
        end else if (p2) begin
          mo.emit        = 1'b1;
          mo.piece.start = acc.stop[19:0];
          mo.piece.stop  = head.stop;
        end
      end
    end else if (!inserted) begin
      mo.emit       = 1'b1;
      mo.piece      = acc;
      inserted_next = 1'b1;
    end else begin
      mo.done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v   <= 1'b0;
      inserted <= 1'b1;
      add_mode <= 1'b0;
    end else if (load) begin
      orig     <= init;
      acc      <= init;
      add_mode <= is_add_in;
      inserted <= !is_add_in;
      pend_v   <= 1'b0;
    end else if (restart) begin
      acc      <= orig;
      inserted <= !add_mode;
      pend_v   <= 1'b0;
    end else if (step) begin
      acc      <= acc_next;
      inserted <= inserted_next;
      pend_v   <= pend_v_next;
      pend     <= pend_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/free_page_range_allocator_unit.sv
// top level of the free page range allocator
//
// usage: one item on the s_ side asks to add a free byte range, remove a
// range or allocate one 4 KiB page; exactly one result item comes back on
// the m_ side with the allocated page address, a status and the number of
// free ranges held afterwards.
// the free ranges sit sorted by start in a chain of MAX_RANGES cells that
// shift toward cell 0; a range processor at the head reads cell 0.
// add and remove run a counting pass (the chain rotates once around, the
// processor counts the ranges the result would need), then a rebuild pass
// that pops old ranges off the head and writes new ones behind the rest.
// a table-full result comes back after the counting pass, with no rebuild
// pass. allocate, empty and unknown items skip both passes. items are handled
// one at a time: the next item is taken only once the result of the last one
// is in the output register.
// a result that would not fit the table leaves it unchanged (table full).
// if the receiver stalls, the block waits with a finished result
// until the output register frees up.
// reset empties the table and drops any result not yet taken.
`default_nettype none
module free_page_range_allocator_unit #(
  parameter int MAX_RANGES = frpa_pkg::MAX_RANGES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // action[1:0], base_address[33:2], length_bytes[65:34], zero pad
  input  wire logic [frpa_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // page_address[31:0], status[33:32], ranges_held[39:34]
  output logic [frpa_pkg::M_TDATA_W-1:0]        m_tdata
);

  localparam int CW = $clog2(MAX_RANGES + 2);
  localparam int IW = $clog2(MAX_RANGES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_DRY   = 7'b0000100,
    S_ALIGN = 7'b0001000,
    S_WET   = 7'b0010000,
    S_ALLOC = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state;

  // latched item
  frpa_pkg::action_t act;
  logic [31:0]       base;
  logic [31:0]       len;

  logic [CW-1:0] total;
  logic [CW-1:0] remain;
  logic [CW-1:0] written;
  logic [CW-1:0] spin;
  logic [CW-1:0] wpos;
  logic          full;

  frpa_pkg::status_t res_status;
  logic [31:0]       res_addr;

  frpa_pkg::extent_t   cells [MAX_RANGES];
  frpa_pkg::cell_ctrl_t ctrl [MAX_RANGES];
  frpa_pkg::merge_out_t mo;
  frpa_pkg::extent_t   init_ext;
  logic                m_load;
  logic                m_restart;
  logic                m_step;
  logic                shift_g;
  logic                wr_g;
  logic                bump_g;

  // range rounding for add and remove
  logic [11:0] diff;
  logic [32:0] start_byte;
  logic [31:0] eff;
  logic [20:0] sp;
  logic [20:0] room;
  logic [20:0] pg;
  logic [32:0] end_byte;
  logic [33:0] re_sum;
  logic [21:0] re_wide;
  logic [20:0] re;
  logic [CW+5:0] held_wide;

  always_comb begin
    diff       = (~base[11:0] + 12'd1) & frpa_pkg::PAGE_MASK;
    start_byte = {1'b0, base} + {21'b0, diff};
    eff        = (len > {20'b0, diff}) ? (len - {20'b0, diff}) : 32'd0;
    sp         = start_byte[32:12];
    room       = (sp >= frpa_pkg::PAGE_LIMIT) ? 21'd0 : (frpa_pkg::PAGE_LIMIT - sp);
    pg         = ({1'b0, eff[31:12]} > room) ? room : {1'b0, eff[31:12]};
    end_byte   = {1'b0, base} + {1'b0, len};
    re_sum     = {1'b0, end_byte} + {22'b0, frpa_pkg::PAGE_MASK};
    re_wide    = re_sum[33:12];
    re         = (re_wide > {1'b0, frpa_pkg::PAGE_LIMIT}) ? frpa_pkg::PAGE_LIMIT
                                                          : re_wide[20:0];
  end

  always_comb begin
    if (act == frpa_pkg::ACT_ADD) begin
      init_ext.start = sp[19:0];
      init_ext.stop  = sp + pg;
    end else begin
      init_ext.start = base[31:12];
      init_ext.stop  = re;
    end
  end

  // head processor steps in both passes
  assign m_step    = (state == S_DRY) || (state == S_WET);
  assign m_load    = (state == S_PREP);
  assign m_restart = (state == S_ALIGN) && (spin == '0);

  frpa_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (m_load),
    .restart   (m_restart),
    .step      (m_step),
    .is_add_in (act == frpa_pkg::ACT_ADD),
    .init      (init_ext),
    .head      (cells[0]),
    .have_old  (remain != '0),
    .mo        (mo)
  );

  logic alloc_pop;
  assign alloc_pop = (state == S_ALLOC) && (total != '0) &&
                     (({1'b0, cells[0].start} + 21'd1) == cells[0].stop);

  always_comb begin
    shift_g = 1'b0;
    wr_g    = 1'b0;
    bump_g  = 1'b0;
    case (state)
      S_DRY:   shift_g = mo.pop;
      S_ALIGN: shift_g = (spin != '0);
      S_WET: begin
        shift_g = mo.pop;
        wr_g    = mo.emit;
      end
      S_ALLOC: begin
        shift_g = alloc_pop;
        bump_g  = (total != '0) && !alloc_pop;
      end
      default: ;
    endcase
  end

  // new ranges land just behind the old ones still waiting
  assign wpos = remain + written - {{(CW-1){1'b0}}, mo.pop};

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    frpa_pkg::extent_t nb;
    if (i < MAX_RANGES - 1) begin : g_mid
      assign nb = cells[i+1];
    end else begin : g_tail
      assign nb = cells[0];
    end
    assign ctrl[i].shift = shift_g;
    assign ctrl[i].wr    = wr_g && (wpos[IW-1:0] == IW'(i));
    assign ctrl[i].bump  = bump_g && (i == 0);
    frpa_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .from_next (nb),
      .wr_data   (mo.piece),
      .q         (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a result taken while a new one loads is reloaded in S_FIN
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act   <= frpa_pkg::action_t'(s_tdata[1:0]);
            base  <= s_tdata[33:2];
            len   <= s_tdata[65:34];
            state <= S_PREP;
          end
        end
        S_PREP: begin
          res_addr <= 32'd0;
          remain   <= total;
          written  <= '0;
          case (act)
            frpa_pkg::ACT_ADD: begin
              if (pg == 21'd0) begin
                res_status <= frpa_pkg::ST_EMPTY;
                state      <= S_FIN;
              end else begin
                res_status <= frpa_pkg::ST_OK;
                state      <= S_DRY;
              end
            end
            frpa_pkg::ACT_REMOVE: begin
              if (len == 32'd0) begin
                res_status <= frpa_pkg::ST_EMPTY;
                state      <= S_FIN;
              end else begin
                res_status <= frpa_pkg::ST_OK;
                state      <= S_DRY;
              end
            end
            frpa_pkg::ACT_ALLOC: begin
              res_status <= frpa_pkg::ST_OK;
              state      <= S_ALLOC;
            end
            default: begin
              res_status <= frpa_pkg::ST_OK;
              state      <= S_FIN;
            end
          endcase
        end
        S_DRY: begin
          // counting pass, chain rotates
          if (mo.done) begin
            full  <= written > CW'(MAX_RANGES);
            spin  <= CW'(MAX_RANGES) - total;
            state <= S_ALIGN;
          end else begin
            remain  <= remain - {{(CW-1){1'b0}}, mo.pop};
            written <= written + {{(CW-1){1'b0}}, mo.emit};
          end
        end
        S_ALIGN: begin
          // finish the full turn so cell 0 holds the first range again
          if (spin != '0) begin
            spin <= spin - CW'(1);
          end else if (full) begin
            res_status <= frpa_pkg::ST_FULL;
            state      <= S_FIN;
          end else begin
            remain  <= total;
            written <= '0;
            state   <= S_WET;
          end
        end
        S_WET: begin
          if (mo.done) begin
            total <= written;
            state <= S_FIN;
          end else begin
            remain  <= remain - {{(CW-1){1'b0}}, mo.pop};
            written <= written + {{(CW-1){1'b0}}, mo.emit};
          end
        end
        S_ALLOC: begin
          if (total == '0) begin
            res_status <= frpa_pkg::ST_OOM;
          end else begin
            res_addr <= {cells[0].start, 12'd0};
            if (alloc_pop) begin
              total <= total - CW'(1);
            end
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {held_wide[5:0], res_status, res_addr};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign held_wide = {6'd0, total};
  assign s_tready  = (state == S_IDLE);

endmodule
`default_nettype wire

>>> rtl/frpa_checker.sv
// port checker for the free page range allocator, bound to the top level
`default_nettype none
module frpa_checker #(
  parameter int MAX_RANGES = frpa_pkg::MAX_RANGES_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [frpa_pkg::M_TDATA_W-1:0] m_tdata
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // allocated addresses are page aligned
  a_align: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:0] == 12'd0))
    else $error("page address not aligned");

  // only a successful allocate gives an address
  a_noaddr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] != frpa_pkg::ST_OK) |-> (m_tdata[31:0] == 32'd0))
    else $error("address on failed item");

  // range count stays within the table
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({26'd0, m_tdata[39:34]} <= 32'(MAX_RANGES)) || (MAX_RANGES > 63))
    else $error("range count beyond table size");

endmodule

bind free_page_range_allocator_unit frpa_checker #(.MAX_RANGES(MAX_RANGES)) u_frpa_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

>>> sim/free_page_range_allocator_unit_test.sv
// testbench of the free page range allocator: random and directed items, scoreboarded
`timescale 1ns / 100ps
`default_nettype none
module free_page_range_allocator_unit_test;

  localparam int NSLOTS = 32;
  localparam int TMPN = 2 * NSLOTS + 2;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    frpa_pkg::action_t act;
    logic [31:0]       base;
    logic [31:0]       len;
  } request_t;

  // first member sits in the top bits, matching the result layout
  typedef struct packed {
    logic [5:0]        held;
    frpa_pkg::status_t st;
    logic [31:0]       page;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [frpa_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [frpa_pkg::M_TDATA_W-1:0] m_tdata;

  free_page_range_allocator_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predicted free list, pages [lo, hi)
  logic [20:0] fl_lo [NSLOTS];
  logic [20:0] fl_hi [NSLOTS];
  int fl_cnt = 0;
  logic [20:0] wk_lo [TMPN];
  logic [20:0] wk_hi [TMPN];

  request_t pending_q[$];
  reply_t   replies_q[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  // sort, merge touching ranges, commit if the table holds them
  function automatic bit merge_commit(int n);
    int outn;
    logic [20:0] a, b;
    int j;
    outn = 0;
    for (int i = 1; i < n; i++) begin
      a = wk_lo[i];
      b = wk_hi[i];
      j = i;
      while (j > 0 && wk_lo[j-1] > a) begin
        wk_lo[j] = wk_lo[j-1];
        wk_hi[j] = wk_hi[j-1];
        j--;
      end
      wk_lo[j] = a;
      wk_hi[j] = b;
    end
    for (int i = 0; i < n; i++) begin
      if (outn > 0 && wk_lo[i] <= wk_hi[outn-1]) begin
        if (wk_hi[i] > wk_hi[outn-1]) wk_hi[outn-1] = wk_hi[i];
      end else begin
        wk_lo[outn] = wk_lo[i];
        wk_hi[outn] = wk_hi[i];
        outn++;
      end
    end
    if (outn > NSLOTS) return 0;
    for (int i = 0; i < outn; i++) begin
      fl_lo[i] = wk_lo[i];
      fl_hi[i] = wk_hi[i];
    end
    fl_cnt = outn;
    return 1;
  endfunction

  function automatic reply_t predict_alloc(request_t r);
    reply_t o;
    logic [11:0] diff;
    logic [32:0] sbyte;
    logic [31:0] eff;
    logic [31:0] pages, sp, room;
    logic [32:0] ebyte;
    logic [21:0] re;
    logic [20:0] rs;
    int n;
    o.page = '0;
    o.st = frpa_pkg::ST_OK;
    case (r.act)
      frpa_pkg::ACT_ADD: begin
        diff = 12'(13'h1000 - {1'b0, r.base[11:0]});
        sbyte = {1'b0, r.base} + diff;
        eff = (r.len > diff) ? r.len - diff : 0;
        pages = eff >> 12;
        sp = 32'(sbyte >> 12);
        room = (sp >= 32'h100000) ? 0 : 32'h100000 - sp;
        if (pages > room) pages = room;
        if (pages == 0) o.st = frpa_pkg::ST_EMPTY;
        else begin
          for (int i = 0; i < fl_cnt; i++) begin
            wk_lo[i] = fl_lo[i];
            wk_hi[i] = fl_hi[i];
          end
          wk_lo[fl_cnt] = 21'(sp);
          wk_hi[fl_cnt] = 21'(sp + pages);
          if (!merge_commit(fl_cnt + 1)) o.st = frpa_pkg::ST_FULL;
        end
      end
      frpa_pkg::ACT_REMOVE: begin
        if (r.len == 0) o.st = frpa_pkg::ST_EMPTY;
        else begin
          rs = 21'(r.base >> 12);
          ebyte = {1'b0, r.base} + r.len;
          re = 22'(({1'b0, ebyte} + 34'hFFF) >> 12);
          if (re > 22'h100000) re = 22'h100000;
          n = 0;
          for (int i = 0; i < fl_cnt; i++) begin
            if (re <= fl_lo[i] || rs >= fl_hi[i]) begin
              wk_lo[n] = fl_lo[i]; wk_hi[n] = fl_hi[i]; n++;
            end else begin
              if (fl_lo[i] < rs) begin
                wk_lo[n] = fl_lo[i]; wk_hi[n] = rs; n++;
              end
              if (re < fl_hi[i]) begin
                wk_lo[n] = 21'(re); wk_hi[n] = fl_hi[i]; n++;
              end
            end
          end
          if (!merge_commit(n)) o.st = frpa_pkg::ST_FULL;
        end
      end
      frpa_pkg::ACT_ALLOC: begin
        if (fl_cnt == 0) o.st = frpa_pkg::ST_OOM;
        else begin
          o.page = {fl_lo[0][19:0], 12'h000};
          fl_lo[0] = fl_lo[0] + 1;
          if (fl_lo[0] == fl_hi[0]) begin
            for (int i = 1; i < fl_cnt; i++) begin
              fl_lo[i-1] = fl_lo[i];
              fl_hi[i-1] = fl_hi[i];
            end
            fl_cnt--;
          end
        end
      end
      default: ;
    endcase
    o.held = 6'(fl_cnt);
    return o;
  endfunction

  function automatic request_t mk(frpa_pkg::action_t a, logic [31:0] b, logic [31:0] l);
    request_t r;
    r.act = a;
    r.base = b;
    r.len = l;
    return r;
  endfunction

  // random item, mostly page-aligned small ranges in a narrow window so they interact
  function automatic request_t rand_item();
    request_t r;
    int k;
    k = $urandom_range(0, 99);
    r.act = (k < 40) ? frpa_pkg::ACT_ADD : (k < 65) ? frpa_pkg::ACT_REMOVE :
            (k < 97) ? frpa_pkg::ACT_ALLOC : frpa_pkg::ACT_NONE;
    if ($urandom_range(0, 9) < 8) begin
      r.base = ($urandom_range(0, 255) << 12) + (($urandom_range(0, 3) == 0) ? $urandom : 0) % 4096;
      r.len = ($urandom_range(0, 12) << 12) + (($urandom_range(0, 3) == 0) ? $urandom % 4096 : 0);
      if ($urandom_range(0, 19) == 0) r.base = r.base | 32'hFFF00000;
    end else begin
      r.base = $urandom;
      r.len = $urandom;
    end
    return r;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, pending_q[0].len, pending_q[0].base, pending_q[0].act};
        replies_q.push_back(predict_alloc(pending_q.pop_front()));
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    reply_t got, want;
    cycles <= cycles + 1;
    m_tready <= !rst && ($urandom_range(0, 99) >= stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (replies_q.size() == 0) begin
        $error("result with nothing expected: %h", m_tdata);
        errors = errors + 1;
      end else begin
        want = replies_q.pop_front();
        if (got.page != want.page) begin
          $error("page_address expected %h got %h", want.page, got.page);
          errors = errors + 1;
        end
        if (got.st != want.st) begin
          $error("status expected %0d got %0d", want.st, got.st);
          errors = errors + 1;
        end
        if (got.held != want.held) begin
          $error("ranges_held expected %0d got %0d", want.held, got.held);
          errors = errors + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("[free_page_range_allocator_unit] ERROR");
      $finish;
    end
  end

  task automatic run_phase(int idle, int stall, int count);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) pending_q.push_back(rand_item());
    wait (pending_q.size() == 0);
    wait (replies_q.size() == 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed: empty table, extremes, rounding, split, top of space, full table
    pending_q.push_back(mk(frpa_pkg::ACT_ALLOC, 0, 0));
    pending_q.push_back(mk(frpa_pkg::ACT_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF));
    pending_q.push_back(mk(frpa_pkg::ACT_ADD, 32'h0000_0001, 32'h0000_1FFF));
    pending_q.push_back(mk(frpa_pkg::ACT_ADD, 32'h0000_0FFF, 32'h0000_1000));
    pending_q.push_back(mk(frpa_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0000_0000));
    pending_q.push_back(mk(frpa_pkg::ACT_ADD, 32'h0000_0000, 32'hFFFF_FFFF));
    pending_q.push_back(mk(frpa_pkg::ACT_REMOVE, 32'h0001_0800, 32'h0000_1000));
    pending_q.push_back(mk(frpa_pkg::ACT_REMOVE, 32'hFFFF_F000, 32'hFFFF_FFFF));
    pending_q.push_back(mk(frpa_pkg::ACT_ALLOC, 0, 0));
    pending_q.push_back(mk(frpa_pkg::ACT_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF));
    pending_q.push_back(mk(frpa_pkg::ACT_ADD, 32'hFFFF_E001, 32'hFFFF_FFFF));
    pending_q.push_back(mk(frpa_pkg::ACT_ADD, 32'hFFFF_F000, 32'h0000_1000));
    pending_q.push_back(mk(frpa_pkg::ACT_ALLOC, 0, 0));
    pending_q.push_back(mk(frpa_pkg::ACT_ALLOC, 0, 0));
    pending_q.push_back(mk(frpa_pkg::ACT_ALLOC, 0, 0));
    // fill the table with 33 disjoint one-page ranges, last one overflows
    for (int i = 0; i < 33; i++)
      pending_q.push_back(mk(frpa_pkg::ACT_ADD, i << 13, 32'h1000));
    pending_q.push_back(mk(frpa_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0000_0001));
    pending_q.push_back(mk(frpa_pkg::ACT_ADD, 32'h0004_0000, 32'h0000_1000));
    pending_q.push_back(mk(frpa_pkg::ACT_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF));
    wait (pending_q.size() == 0);
    wait (replies_q.size() == 0);
    run_phase(0, 0, 88);
    run_phase(71, 0, 88);
    run_phase(0, 71, 88);
    run_phase(30, 30, 88);
    repeat (120) @(posedge clk);
    if (errors == 0 && replies_q.size() == 0) begin
      $display("[free_page_range_allocator_unit] OK");
    end else begin
      $display("[free_page_range_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
